[rtl/core/ost_pkg.sv]
// ----------------------------------------------------------------------------
// ost_pkg: shared definitions of the stash table
// opcodes, register indexes, field widths and the shuffle generator step
// ----------------------------------------------------------------------------
`default_nettype none

package ost_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int OPC_W  = 3;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 64;
  localparam int OCC_W  = 6;
  localparam int LFSR_W = 32;
  localparam int CFG_IDX_W = 1;

  // remainder unit retires this many dividend bits per cycle
  localparam int REM_STEP = 4;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 32'h0000_0001;

  localparam logic [OPC_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OPC_W-1:0] OP_UPDATE  = 3'd1;
  localparam logic [OPC_W-1:0] OP_GET     = 3'd2;
  localparam logic [OPC_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OPC_W-1:0] OP_EXISTS  = 3'd4;
  localparam logic [OPC_W-1:0] OP_SIZE    = 3'd5;
  localparam logic [OPC_W-1:0] OP_GET_ALL = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_SEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 1'd1;

  // galois step: shift right, fold taps when a one falls out
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] t;
    t = s >> 1;
    if (s[0]) begin
      t = t ^ LFSR_TAPS;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ost_rem_unit.sv]
// ----------------------------------------------------------------------------
// ost_rem_unit: iterative remainder of a 32-bit word by a narrow divisor
// restoring scheme, REM_STEP dividend bits per cycle, one-cycle done pulse
// ----------------------------------------------------------------------------
`default_nettype none

module ost_rem_unit #(
  parameter int DIV_W = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ost_pkg::LFSR_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]           divisor,
  output logic                            done,
  output logic [DIV_W-1:0]                rem
);
  import ost_pkg::*;

  localparam int N_CYC = LFSR_W / REM_STEP;
  localparam int CYC_W = (N_CYC > 1) ? $clog2(N_CYC) : 1;
  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(N_CYC - 1);

  logic              act_r, act_nxt;
  logic              done_r, done_nxt;
  logic [CYC_W-1:0]  cyc_r, cyc_nxt;
  logic [LFSR_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;

  always_comb begin
    logic [DIV_W:0]    t;
    logic [DIV_W-1:0]  r;
    logic [LFSR_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int k = 0; k < REM_STEP; k++) begin
      t = {r, d[LFSR_W-1]};
      d = d << 1;
      if (t >= {1'b0, dsr_r}) begin
        t = t - {1'b0, dsr_r};
      end
      r = t[DIV_W-1:0];
    end

    act_nxt  = act_r;
    done_nxt = 1'b0;
    cyc_nxt  = cyc_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      act_nxt = 1'b1;
      cyc_nxt = '0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
      rem_nxt = '0;
    end else if (act_r) begin
      rem_nxt = r;
      dvd_nxt = d;
      cyc_nxt = cyc_r + 1'b1;
      if (cyc_r == CYC_LAST) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cyc_r  <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[rtl/core/oram_stash_table.sv]
// ----------------------------------------------------------------------------
// oram_stash_table: bounded key-to-block stash with shuffled dump
// add/update/get/remove/exists/size on a CAPACITY-slot store, and get_all
// that emits every entry in a fisher-yates order driven by a 32-bit lfsr
// ----------------------------------------------------------------------------
//
//  channel   ports                                     handshake
//  --------  ----------------------------------------  ---------------------
//  command   start, busy, in_opcode/in_key/in_data_word transfer on start & !busy
//  result    out_strobe, out_key_out ... out_last      one cycle, no backpressure
//  config    cfg_valid, cfg_ready, cfg_index, cfg_wdata transfer on valid & ready
//
//  add, update, get, remove, exists: a serial scan of the key memory, one slot
//    per cycle, then the update state, whose result is registered. size and the
//    unused opcode answer in the cycle after the command transfer.
//  get_all: a gather pass over all CAPACITY slots for the valid ones, then per draw
//    the steps (lfsr step, remainder unit at 4 bits per cycle, swap through the
//    one-write, one-read order memory), then one entry per cycle out of the memories.
//  reset clears the valid bits, the count and control state at once; there is
//    no clearing pass. the result side cannot stall, so results are never held.
//
`default_nettype none

module oram_stash_table #(
  parameter int CAPACITY = ost_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ost_pkg::OPC_W-1:0]     in_opcode,
  input  wire logic [ost_pkg::KEY_W-1:0]     in_key,
  input  wire logic [ost_pkg::DATA_W-1:0]    in_data_word,
  // result
  output logic                               out_strobe,
  output logic [ost_pkg::KEY_W-1:0]          out_key_out,
  output logic [ost_pkg::DATA_W-1:0]         out_data_out,
  output logic                               out_found,
  output logic                               out_status,
  output logic [ost_pkg::OCC_W-1:0]          out_occupancy,
  output logic                               out_last,
  // config
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ost_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ost_pkg::LFSR_W-1:0]    cfg_wdata
);
  import ost_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  // sequencer codes
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN    = 4'd1;
  localparam logic [3:0] ST_ACT     = 4'd2;
  localparam logic [3:0] ST_GATHER  = 4'd3;
  localparam logic [3:0] ST_SHCHK   = 4'd4;
  localparam logic [3:0] ST_SHSTART = 4'd5;
  localparam logic [3:0] ST_SHDIV   = 4'd6;
  localparam logic [3:0] ST_SHRDJ   = 4'd7;
  localparam logic [3:0] ST_SHWRI   = 4'd8;
  localparam logic [3:0] ST_SHWRJ   = 4'd9;
  localparam logic [3:0] ST_EMIT    = 4'd10;

  logic [3:0] state_r, state_nxt;

  // command held for the whole operation
  logic [OPC_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  // store state
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic                chk_en_r, chk_en_nxt;

  // scan pipeline: issue stage, then compare against registered memory data
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [DATA_W-1:0] hit_data_r, hit_data_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;

  // get_all bookkeeping
  logic [IDX_W-1:0] g_idx_r, g_idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] sh_i_r, sh_i_nxt;
  logic [IDX_W-1:0] sh_j_r, sh_j_nxt;
  logic [IDX_W-1:0] vi_r, vi_nxt;
  logic [CNT_W-1:0] em_idx_r, em_idx_nxt;
  logic             e1_vld_r, e1_vld_nxt, e1_last_r, e1_last_nxt;
  logic             e2_vld_r, e2_vld_nxt, e2_last_r, e2_last_nxt;

  // result register
  logic              out_strobe_r, out_strobe_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_status_r, out_status_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;
  logic              out_last_r, out_last_nxt;

  // memories
  logic [KEY_W-1:0]  key_mem  [CAPACITY];
  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [IDX_W-1:0]  ord_mem  [CAPACITY];
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] data_q;
  logic [IDX_W-1:0]  ord_q;
  logic              key_we, data_we;
  logic [IDX_W-1:0]  kd_waddr, kd_raddr;
  logic              ord_we;
  logic [IDX_W-1:0]  ord_waddr, ord_wdata, ord_raddr;

  // remainder unit for the shuffle draws
  logic              rem_start, rem_done;
  logic [LFSR_W-1:0] rem_dividend;
  logic [CNT_W-1:0]  rem_divisor, rem_q;
  logic [CNT_W-1:0]  sh_left;
  logic [CNT_W-1:0]  j_sum;

  logic cmd_xfer, cfg_xfer;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign cmd_xfer  = start && !busy;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // entries still to be placed, and the drawn swap partner
  assign sh_left = n_r - CNT_W'(sh_i_r);
  assign j_sum   = CNT_W'(sh_i_r) + rem_q;

  ost_rem_unit #(
    .DIV_W (CNT_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem      (rem_q)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    data_nxt     = data_r;
    valid_nxt    = valid_r;
    count_nxt    = count_r;
    lfsr_nxt     = lfsr_r;
    chk_en_nxt   = chk_en_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = scan_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_data_nxt = hit_data_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    g_idx_nxt    = g_idx_r;
    n_nxt        = n_r;
    sh_i_nxt     = sh_i_r;
    sh_j_nxt     = sh_j_r;
    vi_nxt       = vi_r;
    em_idx_nxt   = em_idx_r;
    e1_vld_nxt   = 1'b0;
    e1_last_nxt  = 1'b0;
    e2_vld_nxt   = e1_vld_r;
    e2_last_nxt  = e1_last_r;

    out_strobe_nxt = 1'b0;
    out_key_nxt    = out_key_r;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;

    key_we    = 1'b0;
    data_we   = 1'b0;
    kd_waddr  = hit_idx_r;
    kd_raddr  = (state_r == ST_SCAN) ? scan_idx_r : ord_q;
    ord_we    = 1'b0;
    ord_waddr = g_idx_r;
    ord_wdata = g_idx_r;
    ord_raddr = em_idx_r[IDX_W-1:0];

    rem_start    = 1'b0;
    rem_dividend = lfsr_next(lfsr_r);
    rem_divisor  = sh_left;

    // config only lands while idle
    if (cfg_xfer) begin
      unique case (cfg_index)
        REG_SHUFFLE_SEED: lfsr_nxt   = (cfg_wdata == '0) ? LFSR_ONE : cfg_wdata;
        REG_CHECK_ENABLE: chk_en_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_xfer) begin
          op_nxt       = in_opcode;
          key_nxt      = in_key;
          data_nxt     = in_data_word;
          scan_idx_nxt = '0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          g_idx_nxt    = '0;
          n_nxt        = '0;
          unique case (in_opcode)
            OP_ADD, OP_UPDATE, OP_GET, OP_REMOVE, OP_EXISTS: begin
              state_nxt = ST_SCAN;
            end
            OP_GET_ALL: begin
              state_nxt = ST_GATHER;
            end
            default: begin
              // size and the unused code answer at once
              out_strobe_nxt = 1'b1;
              out_key_nxt    = in_key;
              out_data_nxt   = '0;
              out_found_nxt  = 1'b0;
              out_status_nxt = 1'b0;
              out_occ_nxt    = OCC_W'(count_r);
              out_last_nxt   = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + 1'b1;
        cmp_vld_nxt  = !(cmp_vld_r && (cmp_idx_r == IDX_LAST));
        if (cmp_vld_r) begin
          if (valid_r[cmp_idx_r]) begin
            if ((key_q == key_r) && !hit_r) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = cmp_idx_r;
              hit_data_nxt = data_q;
            end
          end else if (!free_r) begin
            // lowest free slot wins
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (cmp_idx_r == IDX_LAST) begin
            state_nxt = ST_ACT;
          end
        end
      end

      ST_ACT: begin
        out_strobe_nxt = 1'b1;
        out_key_nxt    = key_r;
        out_data_nxt   = '0;
        out_found_nxt  = hit_r;
        out_status_nxt = 1'b0;
        out_last_nxt   = 1'b1;
        unique case (op_r)
          OP_ADD, OP_UPDATE: begin
            if (hit_r) begin
              // add keeps the stored block, update overwrites it
              data_we  = (op_r == OP_UPDATE);
              kd_waddr = hit_idx_r;
            end else if (chk_en_r && (count_r >= CNT_FULL)) begin
              out_status_nxt = 1'b1;
            end else if (free_r) begin
              key_we              = 1'b1;
              data_we             = 1'b1;
              kd_waddr            = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              count_nxt           = count_r + 1'b1;
            end
          end
          OP_GET: begin
            out_data_nxt = hit_r ? hit_data_r : '0;
          end
          OP_REMOVE: begin
            if (hit_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
              count_nxt            = count_r - 1'b1;
            end
          end
          default: ;
        endcase
        out_occ_nxt = OCC_W'(count_nxt);
        state_nxt   = ST_IDLE;
      end

      ST_GATHER: begin
        // list valid slots in ascending order
        ord_we    = valid_r[g_idx_r];
        ord_waddr = n_r[IDX_W-1:0];
        ord_wdata = g_idx_r;
        n_nxt     = n_r + CNT_W'(valid_r[g_idx_r]);
        g_idx_nxt = g_idx_r + 1'b1;
        if (g_idx_r == IDX_LAST) begin
          state_nxt = ST_SHCHK;
        end
      end

      ST_SHCHK: begin
        sh_i_nxt   = '0;
        em_idx_nxt = '0;
        if (n_r == '0) begin
          // empty store: a single blank result
          out_strobe_nxt = 1'b1;
          out_key_nxt    = '0;
          out_data_nxt   = '0;
          out_found_nxt  = 1'b0;
          out_status_nxt = 1'b0;
          out_occ_nxt    = OCC_W'(count_r);
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (n_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SHSTART;
        end
      end

      ST_SHSTART: begin
        lfsr_nxt  = lfsr_next(lfsr_r);
        rem_start = 1'b1;
        ord_raddr = sh_i_r;
        state_nxt = ST_SHDIV;
      end

      ST_SHDIV: begin
        ord_raddr = sh_i_r;
        if (rem_done) begin
          vi_nxt    = ord_q;
          sh_j_nxt  = j_sum[IDX_W-1:0];
          state_nxt = ST_SHRDJ;
        end
      end

      ST_SHRDJ: begin
        ord_raddr = sh_j_r;
        state_nxt = ST_SHWRI;
      end

      ST_SHWRI: begin
        ord_we    = 1'b1;
        ord_waddr = sh_i_r;
        ord_wdata = ord_q;
        state_nxt = ST_SHWRJ;
      end

      ST_SHWRJ: begin
        ord_we    = 1'b1;
        ord_waddr = sh_j_r;
        ord_wdata = vi_r;
        if (sh_left > CNT_TWO) begin
          sh_i_nxt  = sh_i_r + 1'b1;
          state_nxt = ST_SHSTART;
        end else begin
          em_idx_nxt = '0;
          state_nxt  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // order read, then key/data read, then the result register
        if (em_idx_r < n_r) begin
          e1_vld_nxt  = 1'b1;
          e1_last_nxt = (em_idx_r == (n_r - 1'b1));
          em_idx_nxt  = em_idx_r + 1'b1;
        end
        if (e2_vld_r) begin
          out_strobe_nxt = 1'b1;
          out_key_nxt    = key_q;
          out_data_nxt   = data_q;
          out_found_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_occ_nxt    = OCC_W'(count_r);
          out_last_nxt   = e2_last_r;
          if (e2_last_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      lfsr_r       <= LFSR_ONE;
      chk_en_r     <= 1'b1;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      e1_vld_r     <= 1'b0;
      e2_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      lfsr_r       <= lfsr_nxt;
      chk_en_r     <= chk_en_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_r        <= hit_nxt;
      free_r       <= free_nxt;
      e1_vld_r     <= e1_vld_nxt;
      e2_vld_r     <= e2_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload and index registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    data_r       <= data_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_data_r   <= hit_data_nxt;
    free_idx_r   <= free_idx_nxt;
    g_idx_r      <= g_idx_nxt;
    n_r          <= n_nxt;
    sh_i_r       <= sh_i_nxt;
    sh_j_r       <= sh_j_nxt;
    vi_r         <= vi_nxt;
    em_idx_r     <= em_idx_nxt;
    e1_last_r    <= e1_last_nxt;
    e2_last_r    <= e2_last_nxt;
    out_key_r    <= out_key_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  // slot memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[kd_waddr] <= key_r;
    end
    if (data_we) begin
      data_mem[kd_waddr] <= data_r;
    end
    key_q  <= key_mem[kd_raddr];
    data_q <= data_mem[kd_raddr];
  end

  // shuffle order memory
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= ord_mem[ord_raddr];
  end

  assign out_strobe    = out_strobe_r;
  assign out_key_out   = out_key_r;
  assign out_data_out  = out_data_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

  // count tracks the valid bits
  a_count_matches_valid: assert property (
    @(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r)
  ) else $error("entry count out of step with valid bits");

  // an add or get_all command transfer makes the block busy
  a_busy_after_cmd: assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd_xfer && ((in_opcode == OP_ADD) || (in_opcode == OP_GET_ALL))) |=> busy
  ) else $error("command transfer did not start an operation");

  // a drawn remainder stays below the number of entries left
  a_draw_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHDIV && rem_done) |-> (rem_q < sh_left)
  ) else $error("shuffle draw out of range");

  // a refused insert only happens on a full store
  a_refuse_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r) |-> (out_last_r && (out_occ_r == OCC_W'(CAPACITY)))
  ) else $error("overflow status on a store that is not full");

endmodule

`default_nettype wire
